// ===== rtl/core/text_console_cursor_scroll_macros.svh =====
// Assertion macros for the console RTL.
// TCCS_ASSERT is inactive while rst is high; TCCS_ASSERT_ALWAYS also checks during reset.
// Both expect signals named clk and rst in the module that uses them.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH

`ifndef SYNTHESIS
`define TCCS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");
`define TCCS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");
`else
`define TCCS_ASSERT(label, prop)
`define TCCS_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== rtl/core/tccs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tccs_pkg;

  // Default screen geometry.
  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  // Fixed field widths.
  localparam int COL_W      = 7;
  localparam int ROW_OUT_W  = 5;
  localparam int CELL_IDX_W = 11;
  localparam int CELL_W     = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CMDQ_DEPTH = 2;

  // Request kinds.
  localparam logic [1:0] KIND_PRINT = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Character codes with special meaning.
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_TAB     = 8'd9;
  localparam logic [7:0] CHAR_BLANK   = 8'd32;
  localparam logic [7:0] TAB_STEP     = 8'd8;

  // Configuration register word indexes and reset values.
  localparam logic REG_FG_COLOR = 1'b0;
  localparam logic REG_BG_COLOR = 1'b1;
  localparam logic [3:0] FG_RESET = 4'd7;
  localparam logic [3:0] BG_RESET = 4'd0;

  // Classified operation handed from the front to the back.
  typedef enum logic [2:0] {
    OP_PRINT,
    OP_NEWLINE,
    OP_TAB,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCROLL,
    ST_FILL,
    ST_READ
  } back_state_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [7:0]            char_code;
    logic [CELL_IDX_W-1:0] cell_index;
  } item_t;

  typedef struct packed {
    logic [COL_W-1:0]     cursor_col;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [CELL_W-1:0]    read_entry;
  } result_t;

  typedef struct packed {
    op_t                   op;
    logic [7:0]            char_code;
    logic [CELL_IDX_W-1:0] cell_index;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/tccs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tccs_ram
  import tccs_pkg::*;
#(
  parameter int WIDTH = CELL_W,
  parameter int DEPTH = COLUMNS_DEFAULT * ROWS_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/tccs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tccs_front
  import tccs_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS    = ROWS_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  output logic       full,
  input  wire item_t item,
  output logic       cmd_valid,
  input  wire logic  cmd_ready,
  output cmd_t       cmd
);

  localparam int CELL_COUNT = COLUMNS * ROWS;

  logic in_range;
  cmd_t cmd_next;
  logic load;

  // Decode the request kind and the special characters into one operation.
  always_comb begin
    in_range           = ({21'd0, item.cell_index} < 32'(CELL_COUNT));
    cmd_next.char_code = item.char_code;
    cmd_next.cell_index = item.cell_index;
    case (item.kind)
      KIND_PRINT: begin
        if (item.char_code == CHAR_NEWLINE) begin
          cmd_next.op = OP_NEWLINE;
        end else if (item.char_code == CHAR_TAB) begin
          cmd_next.op = OP_TAB;
        end else begin
          cmd_next.op = OP_PRINT;
        end
      end
      KIND_CLEAR: cmd_next.op = OP_CLEAR;
      KIND_READ:  cmd_next.op = in_range ? OP_READ : OP_NOP;
      default:    cmd_next.op = OP_NOP;
    endcase
  end

  // The stage takes a new request whenever it is empty or drains this cycle.
  assign full = cmd_valid && !cmd_ready;
  assign load = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (load) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd <= cmd_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tccs_cmd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tccs_cmd_queue
  import tccs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  wire cmd_t wr_data,
  output logic      rd_valid,
  input  wire logic rd_pop,
  output cmd_t      rd_data
);

  localparam int PW = $clog2(CMDQ_DEPTH);

  cmd_t          slots [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (count != (PW + 1)'(CMDQ_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  // Pointers wrap naturally since the depth is a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (PW + 1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (PW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tccs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_cursor_scroll_macros.svh"

module tccs_back
  import tccs_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS    = ROWS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_valid,
  output logic            cmd_pop,
  input  wire cmd_t       cmd,
  input  wire logic [3:0] fg_color,
  input  wire logic [3:0] bg_color,
  output logic            res_valid,
  input  wire logic       res_pop,
  output result_t         result
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int AW = $clog2(CELL_COUNT);
  localparam int RW = $clog2(ROWS);
  localparam logic [AW-1:0] STEP          = AW'(COLUMNS);
  localparam logic [AW-1:0] SCROLL_LAST   = AW'(CELL_COUNT - COLUMNS - 1);
  localparam logic [AW-1:0] FILL_LAST     = AW'(CELL_COUNT - 1);
  localparam logic [RW-1:0] LAST_ROW      = RW'(ROWS - 1);
  localparam logic [7:0]    COLS8         = 8'(COLUMNS);

  back_state_t   state;
  back_state_t   state_next;
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] col_next;
  logic [RW-1:0] row;
  logic [RW-1:0] row_next;
  logic [AW-1:0] row_base;
  logic [AW-1:0] row_base_next;
  logic [AW-1:0] ptr;
  logic [AW-1:0] ptr_next;
  logic          pend;
  logic [AW-1:0] pend_addr;

  logic          take;
  logic [7:0]    col_ext;
  logic [7:0]    col_inc;
  logic [7:0]    col_tab;
  logic          wrap_row;
  logic          at_last;
  logic          need_scroll;
  logic [COL_W-1:0] col_new;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;
  logic [7:0]        attr;
  logic              res_load;
  logic [CELL_W-1:0] res_entry;

  assign attr    = {bg_color, fg_color};
  assign take    = (state == ST_IDLE) && cmd_valid && (!res_valid || res_pop);
  assign col_ext = {1'b0, col};
  assign col_inc = col_ext + 8'd1;
  assign col_tab = col_ext + TAB_STEP;
  assign at_last = (row == LAST_ROW);

  // Cursor motion for the operation at the head of the queue.
  always_comb begin
    case (cmd.op)
      OP_PRINT: begin
        wrap_row = (col_inc >= COLS8);
        col_new  = wrap_row ? '0 : col_inc[COL_W-1:0];
      end
      OP_NEWLINE: begin
        wrap_row = 1'b1;
        col_new  = '0;
      end
      OP_TAB: begin
        wrap_row = (col_tab >= COLS8);
        col_new  = wrap_row ? COL_W'(col_tab - COLS8) : col_tab[COL_W-1:0];
      end
      OP_CLEAR: begin
        wrap_row = 1'b0;
        col_new  = '0;
      end
      default: begin
        wrap_row = 1'b0;
        col_new  = col;
      end
    endcase
    need_scroll = wrap_row && at_last;
  end

  // Cursor and pointer register updates.
  always_comb begin
    col_next      = col;
    row_next      = row;
    row_base_next = row_base;
    if (take) begin
      col_next = col_new;
      if (cmd.op == OP_CLEAR) begin
        row_next      = '0;
        row_base_next = '0;
      end else if (wrap_row && !at_last) begin
        row_next      = row + RW'(1);
        row_base_next = row_base + STEP;
      end
    end
    if (take) begin
      ptr_next = '0;
    end else if (state == ST_SCROLL || (state == ST_FILL && !pend)) begin
      ptr_next = ptr + AW'(1);
    end else begin
      ptr_next = ptr;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take) begin
          if (cmd.op == OP_CLEAR) begin
            state_next = ST_FILL;
          end else if (cmd.op == OP_READ) begin
            state_next = ST_READ;
          end else if (need_scroll) begin
            state_next = ST_SCROLL;
          end
        end
      end
      ST_SCROLL: begin
        if (ptr == SCROLL_LAST) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        if (!pend && ptr == FILL_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Memory port and result controls. A pending scroll copy owns the write port.
  always_comb begin
    cmd_pop   = take;
    mem_we    = 1'b0;
    mem_waddr = ptr;
    mem_wdata = {attr, CHAR_BLANK};
    mem_raddr = AW'(cmd.cell_index);
    res_load  = 1'b0;
    res_entry = '0;
    case (state)
      ST_IDLE: begin
        if (take && cmd.op == OP_PRINT) begin
          mem_we    = 1'b1;
          mem_waddr = row_base + AW'(col);
          mem_wdata = {attr, cmd.char_code};
        end
        res_load = take && !need_scroll && cmd.op != OP_CLEAR && cmd.op != OP_READ;
      end
      ST_SCROLL: begin
        mem_raddr = ptr + STEP;
        mem_we    = pend;
        mem_waddr = pend_addr;
        mem_wdata = mem_rdata;
      end
      ST_FILL: begin
        mem_we = 1'b1;
        if (pend) begin
          mem_waddr = pend_addr;
          mem_wdata = mem_rdata;
        end
        res_load = !pend && ptr == FILL_LAST;
      end
      ST_READ: begin
        res_load  = 1'b1;
        res_entry = mem_rdata;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  tccs_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELL_COUNT)
  ) u_screen (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      col       <= '0;
      row       <= '0;
      row_base  <= '0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state    <= state_next;
      col      <= col_next;
      row      <= row_next;
      row_base <= row_base_next;
      pend     <= (state == ST_SCROLL);
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Sweep pointer, pending copy address and result payload.
  always_ff @(posedge clk) begin
    ptr       <= ptr_next;
    pend_addr <= ptr;
    if (res_load) begin
      result.cursor_col <= col_next;
      result.cursor_row <= ROW_OUT_W'(row_next);
      result.read_entry <= res_entry;
    end
  end

  `TCCS_ASSERT(a_col_in_range, col_ext < COLS8)
  `TCCS_ASSERT(a_row_in_range, row <= LAST_ROW)
  `TCCS_ASSERT(a_row_base_tracks_row, row_base == AW'(row * COLUMNS))
  `TCCS_ASSERT(a_copy_only_in_sweep, pend |-> (state == ST_SCROLL || state == ST_FILL))
  `TCCS_ASSERT_ALWAYS(a_reset_idle, rst |=> (!res_valid && state == ST_IDLE))

endmodule

`default_nettype wire

// ===== rtl/core/text_console_cursor_scroll.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake                    | Payload
// ----------+------------------------------+--------------------------------
// request   | push / full                  | item   (kind, char_code, cell_index)
// result    | empty / pop                  | result (cursor_col, cursor_row, read_entry)
// config    | psel penable pwrite pready   | paddr, pwdata, prdata (fg at 0x0, bg at 0x4)
//
// A print, tab or newline that stays on the screen completes as the back end takes it, while a read
// passes through a read state that fetches the cell from the screen RAM.
// A request that moves below the last row copies the screen up through the screen RAM
// and blanks the bottom line; a clear blanks the whole screen.
// A two-entry command queue lets requests be taken while the back end sweeps the screen, and
// the back end takes no new request while a finished result waits to be popped.

module text_console_cursor_scroll
  import tccs_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS    = ROWS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire item_t                 item,
  output logic                       empty,
  input  wire logic                  pop,
  output result_t                    result,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [3:0] fg_color;
  logic [3:0] bg_color;
  logic       cfg_write;
  logic       reg_sel;

  logic       front_valid;
  logic       front_ready;
  cmd_t       front_cmd;
  logic       queue_valid;
  logic       queue_pop;
  cmd_t       queue_cmd;
  logic       res_valid;

  // Configuration registers.
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= FG_RESET;
      bg_color <= BG_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_FG_COLOR: fg_color <= pwdata[3:0];
        REG_BG_COLOR: bg_color <= pwdata[3:0];
        default:      fg_color <= fg_color;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FG_COLOR: prdata = {(CFG_DATA_W - 4)'(0), fg_color};
      REG_BG_COLOR: prdata = {(CFG_DATA_W - 4)'(0), bg_color};
      default:      prdata = '0;
    endcase
  end

  tccs_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .cmd_valid(front_valid),
    .cmd_ready(front_ready),
    .cmd      (front_cmd)
  );

  tccs_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(front_valid),
    .wr_ready(front_ready),
    .wr_data (front_cmd),
    .rd_valid(queue_valid),
    .rd_pop  (queue_pop),
    .rd_data (queue_cmd)
  );

  tccs_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(queue_valid),
    .cmd_pop  (queue_pop),
    .cmd      (queue_cmd),
    .fg_color (fg_color),
    .bg_color (bg_color),
    .res_valid(res_valid),
    .res_pop  (pop),
    .result   (result)
  );

  assign empty = !res_valid;

endmodule

`default_nettype wire
